// ----- design/assert_macros.svh -----
// assertion macros shared by the frame decoder modules
// no dependencies; every macro samples on clk and is disabled while rst_n is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define RCD_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define RCD_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- design/rcd_pkg.sv -----
// shared types and constants of the radio control frame decoder
// no dependencies
`default_nettype none

package rcd_pkg;

    // channel words kept per frame
    localparam int NUM_CHANNELS = 10;
    localparam int CH_ADDR_W    = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

    // frame layout
    localparam int FRAME_LEN = 32;
    localparam int POS_W     = 5;
    localparam logic [POS_W-1:0] LAST_POS  = POS_W'(FRAME_LEN - 1);
    localparam logic [POS_W-1:0] SUM_LAST  = POS_W'(29);
    localparam logic [POS_W-1:0] FIRST_CH  = POS_W'(3);
    localparam logic [7:0]       HDR0      = 8'h20;
    localparam logic [7:0]       HDR1      = 8'h40;
    localparam logic [15:0]      CSUM_BASE = 16'hFFFF;

    // result status codes
    typedef enum logic [1:0] {
        ST_GOOD       = 2'd0,
        ST_BAD_HEADER = 2'd1,
        ST_BAD_CSUM   = 2'd2
    } status_t;

    // end-of-frame notice from the parser to the emitter
    typedef struct packed {
        logic    start;
        status_t status;
    } frame_done_t;

    // emitter sequencer states
    typedef enum logic [1:0] {
        EM_IDLE,
        EM_READ,
        EM_SHOW
    } em_state_t;

endpackage

`default_nettype wire

// ----- design/rcd_ram.sv -----
// generic single-write, single-read ram with registered read data
// no dependencies
`default_nettype none

module rcd_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 10,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              clk,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]  wr_data,
    input  wire logic              rd_en,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output logic      [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem_reg[rd_addr];
        end
    end

endmodule

`default_nettype wire

// ----- design/rcd_parser.sv -----
// byte parser: position, checksum, header check and channel word staging
// depends on rcd_pkg and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

module rcd_parser
    import rcd_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 accept,
    input  wire logic [7:0]           rx_byte,
    input  wire logic                 restart,
    output logic                      wr_en,
    output logic      [CH_ADDR_W-1:0] wr_addr,
    output logic      [15:0]          wr_data,
    output frame_done_t               done
);

    logic [POS_W-1:0] byte_position_reg, byte_position_next;
    logic [15:0]      running_sum_reg, running_sum_next;
    logic [7:0]       low_byte_hold_reg, low_byte_hold_next;
    logic             header_good_reg, header_good_next;

    logic [POS_W-1:0] ch_off;
    logic [3:0]       ch_num;
    logic [15:0]      word;
    logic [15:0]      expect_sum;
    logic             do_byte;

    // channel slot of an odd position and the word it closes
    assign do_byte    = accept && !restart;
    assign ch_off     = byte_position_reg - FIRST_CH;
    assign ch_num     = ch_off[4:1];
    assign word       = {rx_byte, low_byte_hold_reg};
    assign expect_sum = CSUM_BASE - running_sum_reg;

    // staging store write
    always_comb
    begin
        wr_en   = do_byte && byte_position_reg[0]
                  && (byte_position_reg >= FIRST_CH)
                  && (byte_position_reg <= SUM_LAST)
                  && (ch_num < 4'(NUM_CHANNELS));
        wr_addr = ch_num[CH_ADDR_W-1:0];
        wr_data = word;
    end

    // end of frame verdict
    always_comb
    begin
        done.start  = do_byte && (byte_position_reg == LAST_POS);
        if (!header_good_reg)
        begin
            done.status = ST_BAD_HEADER;
        end
        else if (expect_sum != word)
        begin
            done.status = ST_BAD_CSUM;
        end
        else
        begin
            done.status = ST_GOOD;
        end
    end

    // per-frame state update
    always_comb
    begin
        byte_position_next = byte_position_reg;
        running_sum_next   = running_sum_reg;
        low_byte_hold_next = low_byte_hold_reg;
        header_good_next   = header_good_reg;
        if (accept && restart)
        begin
            byte_position_next = '0;
            running_sum_next   = '0;
            low_byte_hold_next = '0;
            header_good_next   = 1'b1;
        end
        else if (do_byte)
        begin
            if (byte_position_reg == POS_W'(0) && rx_byte != HDR0)
            begin
                header_good_next = 1'b0;
            end
            if (byte_position_reg == POS_W'(1) && rx_byte != HDR1)
            begin
                header_good_next = 1'b0;
            end
            if (byte_position_reg <= SUM_LAST)
            begin
                running_sum_next = running_sum_reg + {8'd0, rx_byte};
            end
            if (!byte_position_reg[0])
            begin
                low_byte_hold_next = rx_byte;
            end
            if (byte_position_reg == LAST_POS)
            begin
                byte_position_next = '0;
                running_sum_next   = '0;
                low_byte_hold_next = '0;
                header_good_next   = 1'b1;
            end
            else
            begin
                byte_position_next = byte_position_reg + POS_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_position_reg <= '0;
            running_sum_reg   <= '0;
            low_byte_hold_reg <= '0;
            header_good_reg   <= 1'b1;
        end
        else
        begin
            byte_position_reg <= byte_position_next;
            running_sum_reg   <= running_sum_next;
            low_byte_hold_reg <= low_byte_hold_next;
            header_good_reg   <= header_good_next;
        end
    end

    // checks
    `RCD_ASSERT_IMP(a_wr_in_range, wr_en, wr_addr < CH_ADDR_W'(NUM_CHANNELS), "staging write out of range")
    `RCD_ASSERT_NXT(a_pos_step, do_byte && byte_position_reg != LAST_POS, byte_position_reg == $past(byte_position_reg) + POS_W'(1), "byte position did not advance")
    `RCD_ASSERT_NXT(a_restart_clears, accept && restart, byte_position_reg == '0 && running_sum_reg == '0 && header_good_reg, "restart left frame state")

endmodule

`default_nettype wire

// ----- design/rcd_emitter.sv -----
// result emitter: reads the staged channel words back and drives the output register
// depends on rcd_pkg and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

module rcd_emitter
    import rcd_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire frame_done_t          done,
    output logic                      busy,
    output logic                      rd_en,
    output logic      [CH_ADDR_W-1:0] rd_addr,
    input  wire logic [15:0]          rd_data,
    output logic                      out_valid,
    input  wire logic                 out_stall,
    output logic      [1:0]           frame_status,
    output logic      [3:0]           channel_index,
    output logic      [15:0]          channel_value,
    output logic                      last
);

    em_state_t              state_reg, state_next;
    logic [CH_ADDR_W-1:0]   idx_reg, idx_next;
    status_t                status_reg, status_next;
    logic [3:0]             index_reg, index_next;
    logic [15:0]            value_reg, value_next;
    logic                   last_reg, last_next;
    logic                   taken;

    assign taken = (state_reg == EM_SHOW) && !out_stall;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            EM_IDLE:
            begin
                if (done.start)
                begin
                    state_next = (done.status == ST_GOOD) ? EM_READ : EM_SHOW;
                end
            end
            EM_READ:
            begin
                state_next = EM_SHOW;
            end
            EM_SHOW:
            begin
                if (!out_stall)
                begin
                    state_next = last_reg ? EM_IDLE : EM_READ;
                end
            end
            default:
            begin
                state_next = EM_IDLE;
            end
        endcase
    end

    // read requests and output register loading
    always_comb
    begin
        rd_en       = 1'b0;
        rd_addr     = idx_reg + CH_ADDR_W'(1);
        idx_next    = idx_reg;
        status_next = status_reg;
        index_next  = index_reg;
        value_next  = value_reg;
        last_next   = last_reg;
        unique case (state_reg)
            EM_IDLE:
            begin
                rd_addr = '0;
                if (done.start)
                begin
                    if (done.status == ST_GOOD)
                    begin
                        rd_en    = 1'b1;
                        idx_next = '0;
                    end
                    else
                    begin
                        status_next = done.status;
                        index_next  = '0;
                        value_next  = '0;
                        last_next   = 1'b1;
                    end
                end
            end
            EM_READ:
            begin
                status_next = ST_GOOD;
                index_next  = 4'(idx_reg);
                value_next  = rd_data;
                last_next   = (idx_reg == CH_ADDR_W'(NUM_CHANNELS - 1));
            end
            EM_SHOW:
            begin
                if (taken && !last_reg)
                begin
                    rd_en    = 1'b1;
                    idx_next = idx_reg + CH_ADDR_W'(1);
                end
            end
            default:
            begin
                rd_en = 1'b0;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= EM_IDLE;
            idx_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        status_reg <= status_next;
        index_reg  <= index_next;
        value_reg  <= value_next;
        last_reg   <= last_next;
    end

    assign busy          = (state_reg != EM_IDLE);
    assign out_valid     = (state_reg == EM_SHOW);
    assign frame_status  = status_reg;
    assign channel_index = index_reg;
    assign channel_value = value_reg;
    assign last          = last_reg;

    // checks
    `RCD_ASSERT_IMP(a_read_issued, state_reg == EM_READ, $past(rd_en), "data load without a read")
    `RCD_ASSERT_NXT(a_last_ends_run, taken && last_reg, !busy, "run continued past last result")
    `RCD_ASSERT_IMP(a_bad_single, out_valid && status_reg != ST_GOOD, last_reg && value_reg == '0, "bad frame result not single")

endmodule

`default_nettype wire

// ----- design/rc_frame_channel_decoder.sv -----
// radio control frame decoder, top level
// depends on rcd_pkg, rcd_ram, rcd_parser and rcd_emitter
//
// usage
// - input channel: rx_byte and restart with in_valid / in_stall; one byte per
//   transaction, frames of 32 bytes counted from reset or the last restart
// - restart high drops the partial frame; its rx_byte is ignored
// - output channel: frame_status, channel_index, channel_value, last with
//   out_valid / out_stall, held in an output register
// - only byte 31 of a frame produces results
// - good frame: NUM_CHANNELS channel transactions, each a staging ram read
//   followed by an output register load, the next read issued once the shown
//   one is taken, last set on the final one
// - bad header or checksum: one status transaction, shown in the cycle after byte 31
// - in_stall stays high from byte 31 until the last result is taken, so a
//   receiver stall holds the output register and backs up the byte stream
// - reset clears position, checksum, header flag and the emitter; the
//   staging ram is not cleared, every entry is written before it is read
`default_nettype none

module rc_frame_channel_decoder
    import rcd_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [7:0]  rx_byte,
    input  wire logic        restart,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic      [1:0]  frame_status,
    output logic      [3:0]  channel_index,
    output logic      [15:0] channel_value,
    output logic             last
);

    logic                 accept;
    logic                 busy;
    logic                 wr_en;
    logic [CH_ADDR_W-1:0] wr_addr;
    logic [15:0]          wr_data;
    logic                 rd_en;
    logic [CH_ADDR_W-1:0] rd_addr;
    logic [15:0]          rd_data;
    frame_done_t          done;

    // bytes are held off while a result run is in progress
    assign in_stall = busy;
    assign accept   = in_valid && !busy;

    rcd_parser u_parser (
        .clk     (clk),
        .rst_n   (rst_n),
        .accept  (accept),
        .rx_byte (rx_byte),
        .restart (restart),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .done    (done)
    );

    // staging store for the channel words of the current frame
    rcd_ram #(
        .WIDTH (16),
        .DEPTH (NUM_CHANNELS)
    ) u_stage_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    rcd_emitter u_emitter (
        .clk           (clk),
        .rst_n         (rst_n),
        .done          (done),
        .busy          (busy),
        .rd_en         (rd_en),
        .rd_addr       (rd_addr),
        .rd_data       (rd_data),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .frame_status  (frame_status),
        .channel_index (channel_index),
        .channel_value (channel_value),
        .last          (last)
    );

endmodule

`default_nettype wire

// ----- bench/tb.sv -----
`timescale 1ns / 1ps
// testbench for rc_frame_channel_decoder: a directed table of frames, then random frames
// depends on rcd_pkg and rc_frame_channel_decoder; checks every output transaction

module tb;
    import rcd_pkg::*;

    // frame content styles for the channel bytes
    typedef enum logic [1:0] {
        FILL_ZERO,
        FILL_ONES,
        FILL_RAMP,
        FILL_RANDOM
    } fill_t;

    // one output transaction of the decoder
    typedef struct packed {
        status_t     status;
        logic [3:0]  index;
        logic [15:0] value;
        logic        last;
    } chan_result_t;

    // one directed frame; a typed row carries its expected status outright
    typedef struct packed {
        logic [7:0]  hdr0;
        logic [7:0]  hdr1;
        fill_t       fill;
        logic [15:0] csum_flip;
        int          restart_at;
        bit          typed;
        status_t     status;
    } frame_row_t;

    localparam int NO_RESTART       = -1;
    localparam int RANDOM_ITEMS     = 96;
    localparam int LONG_HOLD_AT     = 230;
    localparam int LONG_HOLD_CYCLES = 300;
    localparam int DRAIN_CYCLES     = 2 * NUM_CHANNELS + 12;
    localparam int TIMEOUT_NS       = 2_000_000;

    localparam frame_row_t DIRECTED_ROWS [6] = '{
        '{HDR0,  HDR1,  FILL_ZERO,   16'h0000, NO_RESTART, 1'b0, ST_GOOD},
        '{HDR0,  HDR1,  FILL_ONES,   16'h0000, NO_RESTART, 1'b0, ST_GOOD},
        '{8'hFF, 8'h00, FILL_ONES,   16'h1234, NO_RESTART, 1'b1, ST_BAD_HEADER},
        '{HDR0,  HDR1,  FILL_RAMP,   16'h0001, NO_RESTART, 1'b1, ST_BAD_CSUM},
        '{HDR0,  HDR1,  FILL_RAMP,   16'h0000, 0,          1'b0, ST_GOOD},
        '{HDR0,  HDR1,  FILL_RANDOM, 16'h0000, 17,         1'b0, ST_GOOD}
    };

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [7:0]  rx_byte;
    logic        restart;
    logic        out_valid;
    logic        out_stall;
    logic [1:0]  frame_status;
    logic [3:0]  channel_index;
    logic [15:0] channel_value;
    logic        last;

    // decoder mirror state
    logic [POS_W-1:0] rx_pos;
    logic [15:0]      rx_sum;
    logic [7:0]       low_hold;
    logic             hdr_ok;
    logic [15:0]      staged_words [NUM_CHANNELS];
    logic [15:0]      held_words [NUM_CHANNELS];
    chan_result_t     frame_results_due [$];

    // typed expectation that travels with the byte being offered
    bit      typed_due;
    status_t typed_status;

    logic [7:0] frame_bytes [FRAME_LEN];

    int failures;
    int bytes_taken;
    int bytes_offered;
    int restarts_taken;
    int good_frames;
    int bad_frames;
    int results_checked;

    rc_frame_channel_decoder i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .rx_byte       (rx_byte),
        .restart       (restart),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .frame_status  (frame_status),
        .channel_index (channel_index),
        .channel_value (channel_value),
        .last          (last)
    );

    // 4 ns clock
    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    task automatic report_failure(input string msg);
        $display("%0t ns: %s", $time, msg);
        failures++;
    endtask

    task automatic clear_frame_state();
        rx_pos   = '0;
        rx_sum   = '0;
        low_hold = '0;
        hdr_ok   = 1'b1;
    endtask

    // mirror of the decoder for one accepted byte transaction
    task automatic decode_rx_byte(input logic [7:0] b, input logic rs);
        logic [POS_W-1:0] pos;
        logic [15:0]      word;
        int               ch;
        chan_result_t     fresh [$];

        pos = rx_pos;
        if (rs)
        begin
            restarts_taken++;
            clear_frame_state();
            return;
        end

        // header bytes
        if (pos == 0 && b != HDR0)
            hdr_ok = 1'b0;
        if (pos == 1 && b != HDR1)
            hdr_ok = 1'b0;

        if (pos <= SUM_LAST)
            rx_sum = rx_sum + 16'(b);

        // little-endian channel words, extra words are only summed
        if (!pos[0])
            low_hold = b;
        else if (pos >= FIRST_CH && pos <= SUM_LAST)
        begin
            ch = (int'(pos) - int'(FIRST_CH)) >> 1;
            if (ch < NUM_CHANNELS)
                staged_words[ch] = {b, low_hold};
        end

        if (pos != LAST_POS)
        begin
            rx_pos = pos + 1'b1;
            return;
        end

        // end of frame: header check wins over checksum
        word = {b, low_hold};
        if (!hdr_ok)
        begin
            fresh.push_back('{ST_BAD_HEADER, 4'd0, 16'd0, 1'b1});
            bad_frames++;
        end
        else if (16'(CSUM_BASE - rx_sum) != word)
        begin
            fresh.push_back('{ST_BAD_CSUM, 4'd0, 16'd0, 1'b1});
            bad_frames++;
        end
        else
        begin
            for (int i = 0; i < NUM_CHANNELS; i++)
            begin
                held_words[i] = staged_words[i];
                fresh.push_back('{ST_GOOD, 4'(i), held_words[i], i == NUM_CHANNELS - 1});
            end
            good_frames++;
        end

        if (typed_due)
            frame_results_due.push_back('{typed_status, 4'd0, 16'd0, 1'b1});
        else
            foreach (fresh[i])
                frame_results_due.push_back(fresh[i]);
        clear_frame_state();
    endtask

    task automatic check_result();
        chan_result_t want;

        if (frame_results_due.size() == 0)
        begin
            report_failure($sformatf("unexpected transaction: status %0d index %0d value %0h",
                                     frame_status, channel_index, channel_value));
            return;
        end
        want = frame_results_due.pop_front();
        results_checked++;
        if (frame_status !== want.status)
            report_failure($sformatf("frame_status got %0d expected %0d",
                                     frame_status, want.status));
        if (channel_index !== want.index)
            report_failure($sformatf("channel_index got %0d expected %0d",
                                     channel_index, want.index));
        if (channel_value !== want.value)
            report_failure($sformatf("channel_value got %0h expected %0h",
                                     channel_value, want.value));
        if (last !== want.last)
            report_failure($sformatf("last got %0b expected %0b", last, want.last));
    endtask

    // monitor: outputs first, a result can never stem from the byte taken at the same edge
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
                check_result();
            if (in_valid && !in_stall)
            begin
                bytes_taken++;
                decode_rx_byte(rx_byte, restart);
            end
        end
    end

    // mostly short gaps, a few long ones
    function automatic int gap_cycles();
        int r;

        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [7:0] pick_byte();
        int r;

        r = $urandom_range(0, 9);
        if (r < 2)
            return 8'h00;
        if (r < 4)
            return 8'hFF;
        return 8'($urandom);
    endfunction

    // frame with the checksum fixed up, then optionally spoilt
    task automatic make_frame(input logic [7:0] h0, input logic [7:0] h1, input fill_t fill,
                              input logic [15:0] flip);
        logic [15:0] sum;
        logic [15:0] csum;

        frame_bytes[0] = h0;
        frame_bytes[1] = h1;
        for (int i = 2; i <= int'(SUM_LAST); i++)
        begin
            case (fill)
                FILL_ZERO: frame_bytes[i] = 8'h00;
                FILL_ONES: frame_bytes[i] = 8'hFF;
                FILL_RAMP: frame_bytes[i] = 8'(i * 37 + 5);
                default:   frame_bytes[i] = pick_byte();
            endcase
        end
        sum = '0;
        for (int i = 0; i <= int'(SUM_LAST); i++)
            sum = sum + 16'(frame_bytes[i]);
        csum = 16'(CSUM_BASE - sum) ^ flip;
        frame_bytes[FRAME_LEN-2] = csum[7:0];
        frame_bytes[FRAME_LEN-1] = csum[15:8];
    endtask

    task automatic pause_sender(input int n);
        repeat (n)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
            rx_byte  <= 8'($urandom);
            restart  <= 1'($urandom);
        end
    endtask

    // offer one byte transaction and hold it until taken
    task automatic send_item(input logic [7:0] b, input logic rs, input bit typed,
                             input status_t st);
        @(negedge clk);
        typed_due    = typed;
        typed_status = st;
        in_valid <= 1'b1;
        rx_byte  <= b;
        restart  <= rs;
        bytes_offered++;
        do
            @(posedge clk);
        while (in_stall);
    endtask

    // optional partial frame cut by a restart, then the whole frame
    task automatic send_frame(input int restart_at, input bit typed, input status_t st,
                              input bit calm);
        if (restart_at != NO_RESTART)
        begin
            for (int i = 0; i < restart_at; i++)
            begin
                send_item(frame_bytes[i], 1'b0, 1'b0, ST_GOOD);
                if (!calm)
                    pause_sender(gap_cycles());
            end
            send_item(8'($urandom), 1'b1, 1'b0, ST_GOOD);
        end
        for (int i = 0; i < FRAME_LEN; i++)
        begin
            send_item(frame_bytes[i], 1'b0, typed, st);
            if (!calm)
                pause_sender(gap_cycles());
        end
    endtask

    // receiver: random stalls, calm stretches, one long hold-off
    initial
    begin
        int  stall_left;
        int  calm_left;
        bit  calm;
        bit  held_off;

        out_stall  = 1'b0;
        stall_left = 0;
        calm_left  = 0;
        calm       = 1'b0;
        held_off   = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (!held_off && bytes_taken >= LONG_HOLD_AT)
            begin
                held_off = 1'b1;
                out_stall <= 1'b1;
                repeat (LONG_HOLD_CYCLES - 1)
                    @(negedge clk);
            end
            else if (stall_left > 0)
            begin
                out_stall <= 1'b1;
                stall_left--;
            end
            else
            begin
                if (calm_left == 0)
                begin
                    calm      = ($urandom_range(0, 3) == 0);
                    calm_left = $urandom_range(20, 120);
                end
                else
                    calm_left--;
                out_stall <= 1'b0;
                if (!calm && $urandom_range(0, 3) == 0)
                    stall_left = gap_cycles();
            end
        end
    end

    // sender and run control
    initial
    begin
        frame_row_t  row;
        int          start_count;
        int          r;
        logic [7:0]  h0;
        logic [7:0]  h1;
        logic [15:0] flip;
        int          rat;
        bit          calm;

        rst_n        = 1'b0;
        in_valid     = 1'b0;
        rx_byte      = 8'h00;
        restart      = 1'b0;
        typed_due    = 1'b0;
        typed_status = ST_GOOD;
        failures        = 0;
        bytes_taken     = 0;
        bytes_offered   = 0;
        restarts_taken  = 0;
        good_frames     = 0;
        bad_frames      = 0;
        results_checked = 0;
        clear_frame_state();
        foreach (held_words[i])
        begin
            held_words[i]   = '0;
            staged_words[i] = '0;
        end
        repeat (6)
            @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed frames
        foreach (DIRECTED_ROWS[k])
        begin
            row = DIRECTED_ROWS[k];
            make_frame(row.hdr0, row.hdr1, row.fill, row.csum_flip);
            send_frame(row.restart_at, row.typed, row.status, k[0]);
        end

        // hold the byte stream until every result so far has come out
        pause_sender(1);
        while (frame_results_due.size() != 0)
            @(posedge clk);
        pause_sender($urandom_range(1, 5));

        // random frames, mostly well formed
        start_count = bytes_offered;
        while (bytes_offered - start_count < RANDOM_ITEMS)
        begin
            r    = $urandom_range(0, 99);
            calm = ($urandom_range(0, 3) == 0);
            h0   = HDR0;
            h1   = HDR1;
            flip = '0;
            rat  = NO_RESTART;
            if (r >= 65 && r < 78)
            begin
                case ($urandom_range(0, 2))
                    0: h0 = h0 ^ 8'($urandom_range(1, 255));
                    1: h1 = h1 ^ 8'($urandom_range(1, 255));
                    default:
                    begin
                        h0 = h0 ^ 8'($urandom_range(1, 255));
                        h1 = h1 ^ 8'($urandom_range(1, 255));
                    end
                endcase
                if ($urandom_range(0, 1) == 0)
                    flip = 16'($urandom_range(1, 65535));
            end
            else if (r >= 78 && r < 90)
                flip = 16'($urandom_range(1, 65535));
            else if (r >= 90)
                rat = $urandom_range(0, FRAME_LEN - 1);
            // a stray restart between frames now and then
            if ($urandom_range(0, 19) == 0)
                send_item(8'($urandom), 1'b1, 1'b0, ST_GOOD);
            make_frame(h0, h1, FILL_RANDOM, flip);
            send_frame(rat, 1'b0, ST_GOOD, calm);
        end

        // drain
        pause_sender(1);
        while (frame_results_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES)
            @(posedge clk);

        $display("run covered %0d byte transactions (%0d restarts), %0d good and %0d bad frames",
                 bytes_taken, restarts_taken, good_frames, bad_frames);
        $display("%0d output transactions checked, %0d failures", results_checked, failures);
        if (failures == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    // hang guard
    initial
    begin
        #(TIMEOUT_NS);
        $display("timeout with %0d results still due", frame_results_due.size());
        $display("Test completed with failures");
        $finish;
    end

endmodule
